// ----- hw/rtl/three_band_priority_fifo_macros.svh -----
// Assertion helpers for the checker of the three-band queue.
`ifndef THREE_BAND_PRIORITY_FIFO_MACROS_SVH
`define THREE_BAND_PRIORITY_FIFO_MACROS_SVH

// same-cycle implication, quiet during reset
`define TBPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define TBPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checked in every cycle, reset included
`define TBPF_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tbpf_pkg.sv -----
package tbpf_pkg;

   localparam int unsigned TBPF_BAND_DEPTH = 1024;
   localparam int unsigned NUM_BANDS       = 3;
   localparam int unsigned LIMIT_W         = 11;
   localparam int unsigned ENTRY_W         = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_PEEK    = 2'd2;
   localparam logic [1:0] ACT_REQUEUE = 2'd3;

   localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [2:0] STATUS_DROPPED  = 3'd1;
   localparam logic [2:0] STATUS_POPPED   = 3'd2;
   localparam logic [2:0] STATUS_HELD     = 3'd3;
   localparam logic [2:0] STATUS_EMPTY    = 3'd4;
   localparam logic [2:0] STATUS_PEEKED   = 3'd5;
   localparam logic [2:0] STATUS_REQUEUED = 3'd6;

   localparam logic [1:0] PRIO_BAND_MAP [16] = '{
      2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0,
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
   };

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] push_band;
   } tbpf_band_cmd_type;

   typedef struct packed {
      logic       nonempty;
      logic [1:0] first_band;
      logic [2:0] full;
   } tbpf_band_stat_type;

   function automatic logic [1:0] tbpf_band_of(input logic [3:0] prio);
      return PRIO_BAND_MAP[prio];
   endfunction

endpackage

// ----- hw/rtl/tbpf_channels_if.sv -----
interface tbpf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [3:0]  priority_req;
   logic [15:0] packet_handle;
   logic [15:0] packet_bytes;

   modport source (output valid, action, priority_req, packet_handle, packet_bytes,
                   input ready);
   modport sink   (input valid, action, priority_req, packet_handle, packet_bytes,
                   output ready);
endinterface

interface tbpf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] out_handle;
   logic [15:0] out_bytes;
   logic [1:0]  out_band;
   logic [10:0] queued_total;
   logic [31:0] held_packets;
   logic [31:0] held_bytes;

   modport source (output valid, status, out_handle, out_bytes, out_band, queued_total,
                   held_packets, held_bytes, input ready);
   modport sink   (input valid, status, out_handle, out_bytes, out_band, queued_total,
                   held_packets, held_bytes, output ready);
endinterface

interface tbpf_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/tbpf_ram.sv -----
module tbpf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 3072,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tbpf_bands.sv -----
module tbpf_bands #(
   parameter int unsigned BAND_DEPTH = 1024,
   localparam int unsigned ADDR_W    = $clog2(3 * BAND_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tbpf_pkg::tbpf_band_cmd_type  cmd,
   output tbpf_pkg::tbpf_band_stat_type stat,
   output logic [ADDR_W-1:0]            head_addr,
   output logic [ADDR_W-1:0]            tail_addr
);
   import tbpf_pkg::*;

   localparam int unsigned PTR_W = $clog2(BAND_DEPTH);
   localparam int unsigned CNT_W = $clog2(BAND_DEPTH + 1);

   logic [PTR_W-1:0] head_ff  [NUM_BANDS];
   logic [PTR_W-1:0] head_in  [NUM_BANDS];
   logic [PTR_W-1:0] tail_ff  [NUM_BANDS];
   logic [PTR_W-1:0] tail_in  [NUM_BANDS];
   logic [CNT_W-1:0] count_ff [NUM_BANDS];
   logic [CNT_W-1:0] count_in [NUM_BANDS];
   logic             push_hit;
   logic             pop_hit;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] pos);
      return (pos == PTR_W'(BAND_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] band_base(input logic [1:0] band);
      logic [ADDR_W-1:0] base;
      case (band)
         2'd1:    base = ADDR_W'(BAND_DEPTH);
         2'd2:    base = ADDR_W'(2 * BAND_DEPTH);
         default: base = '0;
      endcase
      return base;
   endfunction

   always_comb begin
      stat.nonempty = 1'b0;
      stat.first_band = 2'd2;
      if (count_ff[0] != '0) begin
         stat.first_band = 2'd0;
      end else if (count_ff[1] != '0) begin
         stat.first_band = 2'd1;
      end
      for (int b = 0; b < NUM_BANDS; b++) begin
         stat.full[b] = (count_ff[b] == CNT_W'(BAND_DEPTH));
         if (count_ff[b] != '0) begin
            stat.nonempty = 1'b1;
         end
      end
   end

   assign head_addr = band_base(stat.first_band) + ADDR_W'(head_ff[stat.first_band]);
   assign tail_addr = band_base(cmd.push_band) + ADDR_W'(tail_ff[cmd.push_band]);

   always_comb begin
      push_hit = 1'b0;
      pop_hit  = 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
         push_hit    = cmd.push && (cmd.push_band == 2'(b));
         pop_hit     = cmd.pop && (stat.first_band == 2'(b));
         head_in[b]  = pop_hit ? next_slot(head_ff[b]) : head_ff[b];
         tail_in[b]  = push_hit ? next_slot(tail_ff[b]) : tail_ff[b];
         count_in[b] = count_ff[b];
         if (push_hit) begin
            count_in[b] = count_ff[b] + 1'b1;
         end else if (pop_hit) begin
            count_in[b] = count_ff[b] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            head_ff[b]  <= '0;
            tail_ff[b]  <= '0;
            count_ff[b] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/three_band_priority_fifo.sv -----
// Enqueue, requeue, held-slot dequeue and empty answers appear on rsp in the cycle after the
// req beat; band dequeue and peek pass the registered memory read first, then the rsp register.
// Throughput: one item per cycle for enqueue and requeue; a band read holds off req until its
// entry is back from the band memory's single read port. A result waiting on rsp blocks req.
// Reset (synchronous): clears band pointers and counts, held slot and counters, sets the limit
// to 1000; band memory contents are left as they are and are never read before written.
module three_band_priority_fifo #(
   parameter int unsigned BAND_DEPTH = tbpf_pkg::TBPF_BAND_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   tbpf_req_if.sink    req_ch,
   tbpf_rsp_if.source  rsp_ch,
   tbpf_csr_if.sink    csr_ch
);
   import tbpf_pkg::*;

   localparam int unsigned ADDR_W = $clog2(3 * BAND_DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [LIMIT_W-1:0]  stored_ff, stored_in;
   logic                held_valid_ff, held_valid_in;
   logic [ENTRY_W-1:0]  held_entry_ff, held_entry_in;
   logic [31:0]         held_pkts_ff, held_pkts_in;
   logic [31:0]         held_bytes_ff, held_bytes_in;
   logic [2:0]          pend_status_ff, pend_status_in;
   logic [1:0]          pend_band_ff, pend_band_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [15:0]         rsp_handle_ff, rsp_handle_in;
   logic [15:0]         rsp_bytes_ff, rsp_bytes_in;
   logic [1:0]          rsp_band_ff, rsp_band_in;
   logic [LIMIT_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [31:0]         rsp_hpkts_ff, rsp_hpkts_in;
   logic [31:0]         rsp_hbytes_ff, rsp_hbytes_in;

   logic                req_fire;
   logic                load;
   logic [1:0]          enq_band;
   logic                wr_en;
   logic                rd_en;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ADDR_W-1:0]   head_addr;
   logic [ADDR_W-1:0]   tail_addr;
   tbpf_band_cmd_type   band_cmd;
   tbpf_band_stat_type  band_stat;

   tbpf_bands #(
      .BAND_DEPTH (BAND_DEPTH)
   ) u_bands (
      .clock     (clock),
      .reset     (reset),
      .cmd       (band_cmd),
      .stat      (band_stat),
      .head_addr (head_addr),
      .tail_addr (tail_addr)
   );

   tbpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (3 * BAND_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_addr),
      .wr_data ({req_ch.packet_handle, req_ch.packet_bytes}),
      .rd_en   (rd_en),
      .rd_addr (head_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign limit_in     = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : limit_ff;
   assign enq_band     = tbpf_band_of(req_ch.priority_req);

   always_comb begin
      state_in       = state_ff;
      stored_in      = stored_ff;
      held_valid_in  = held_valid_ff;
      held_entry_in  = held_entry_ff;
      held_pkts_in   = held_pkts_ff;
      held_bytes_in  = held_bytes_ff;
      pend_status_in = pend_status_ff;
      pend_band_in   = pend_band_ff;
      band_cmd       = '0;
      band_cmd.push_band = enq_band;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      load           = 1'b0;
      rsp_status_in  = STATUS_EMPTY;
      rsp_handle_in  = '0;
      rsp_bytes_in   = '0;
      rsp_band_in    = '0;

      if (state_ff == ST_READ) begin
         // band entry arrives from memory this cycle
         load          = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_handle_in = rd_data[31:16];
         rsp_bytes_in  = rd_data[15:0];
         rsp_band_in   = pend_band_ff;
         state_in      = ST_IDLE;
      end else if (req_fire) begin
         unique case (req_ch.action)
            ACT_ENQUEUE: begin
               load        = 1'b1;
               rsp_band_in = enq_band;
               if ((stored_ff >= limit_ff) || band_stat.full[enq_band]) begin
                  rsp_status_in = STATUS_DROPPED;
               end else begin
                  band_cmd.push = 1'b1;
                  wr_en         = 1'b1;
                  stored_in     = stored_ff + 1'b1;
                  rsp_status_in = STATUS_ACCEPTED;
               end
            end
            ACT_DEQUEUE: begin
               if (held_valid_ff) begin
                  load          = 1'b1;
                  rsp_status_in = STATUS_HELD;
                  rsp_handle_in = held_entry_ff[31:16];
                  rsp_bytes_in  = held_entry_ff[15:0];
                  held_valid_in = 1'b0;
                  held_entry_in = '0;
                  held_pkts_in  = held_pkts_ff - 32'd1;
                  held_bytes_in = held_bytes_ff - {16'd0, held_entry_ff[15:0]};
               end else if (band_stat.nonempty) begin
                  band_cmd.pop   = 1'b1;
                  rd_en          = 1'b1;
                  stored_in      = stored_ff - 1'b1;
                  pend_status_in = STATUS_POPPED;
                  pend_band_in   = band_stat.first_band;
                  state_in       = ST_READ;
               end else begin
                  load = 1'b1;
               end
            end
            ACT_PEEK: begin
               if (band_stat.nonempty) begin
                  rd_en          = 1'b1;
                  pend_status_in = STATUS_PEEKED;
                  pend_band_in   = band_stat.first_band;
                  state_in       = ST_READ;
               end else begin
                  load = 1'b1;
               end
            end
            ACT_REQUEUE: begin
               load          = 1'b1;
               rsp_status_in = STATUS_REQUEUED;
               held_valid_in = 1'b1;
               held_entry_in = {req_ch.packet_handle, req_ch.packet_bytes};
               held_pkts_in  = held_pkts_ff + 32'd1;
               held_bytes_in = held_bytes_ff + {16'd0, req_ch.packet_bytes};
            end
            default: begin
            end
         endcase
      end

      rsp_total_in  = stored_in;
      rsp_hpkts_in  = held_pkts_in;
      rsp_hbytes_in = held_bytes_in;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         stored_ff     <= '0;
         held_valid_ff <= 1'b0;
         held_entry_ff <= '0;
         held_pkts_ff  <= '0;
         held_bytes_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         stored_ff     <= stored_in;
         held_valid_ff <= held_valid_in;
         held_entry_ff <= held_entry_in;
         held_pkts_ff  <= held_pkts_in;
         held_bytes_ff <= held_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_band_ff   <= pend_band_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_band_ff   <= rsp_band_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_hpkts_ff  <= rsp_hpkts_in;
         rsp_hbytes_ff <= rsp_hbytes_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_handle   = rsp_handle_ff;
   assign rsp_ch.out_bytes    = rsp_bytes_ff;
   assign rsp_ch.out_band     = rsp_band_ff;
   assign rsp_ch.queued_total = rsp_total_ff;
   assign rsp_ch.held_packets = rsp_hpkts_ff;
   assign rsp_ch.held_bytes   = rsp_hbytes_ff;

endmodule

// ----- hw/rtl/tbpf_checker.sv -----
`include "three_band_priority_fifo_macros.svh"

module tbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_handle,
   input logic [15:0] rsp_bytes,
   input logic [1:0]  rsp_band
);
   import tbpf_pkg::*;

   // a stalled result beat stays up
   `TBPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")

   `TBPF_ASSERT_ALWAYS(a_rsp_idle_after_reset, $past(reset), !rsp_valid, "rsp valid right after reset")

   // empty answer carries no packet and band zero
   `TBPF_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_status == STATUS_EMPTY), (rsp_handle == 16'd0) && (rsp_bytes == 16'd0) && (rsp_band == 2'd0), "empty answer with payload")

   // enqueue outcomes never report a packet
   `TBPF_ASSERT_NOW(a_enq_zero, rsp_valid && ((rsp_status == STATUS_ACCEPTED) || (rsp_status == STATUS_DROPPED)), (rsp_handle == 16'd0) && (rsp_bytes == 16'd0) && (rsp_band != 2'd3), "enqueue answer with payload")

endmodule

bind three_band_priority_fifo tbpf_checker u_tbpf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_handle (rsp_ch.out_handle),
   .rsp_bytes  (rsp_ch.out_bytes),
   .rsp_band   (rsp_ch.out_band)
);
